// ===== rtl/external_interrupt_controller_defines.svh =====
// Assertion helpers for the external interrupt controller.
`ifndef EXTERNAL_INTERRUPT_CONTROLLER_DEFINES_SVH
`define EXTERNAL_INTERRUPT_CONTROLLER_DEFINES_SVH

// Checked while out of reset.
`define EIC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define EIC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/eic_pkg.sv =====
package eic_pkg;

	localparam int GROUPS          = 4;
	localparam int LINES_PER_GROUP = 8;
	localparam int LINES           = GROUPS * LINES_PER_GROUP;
	localparam int MODE_W          = 3;
	localparam int NIBBLE_W        = 4;
	localparam int WORD_W          = 32;
	localparam int PIN_W           = 32;
	localparam int CMD_W           = 2;
	localparam int KIND_W          = 2;
	localparam int GROUP_W         = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_READ   = 2'd1,
		CMD_WRITE  = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_CTRL = 2'd0,
		KIND_MASK = 2'd1,
		KIND_PEND = 2'd2
	} kind_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOW  = 3'd0,
		MODE_HIGH = 3'd1,
		MODE_FALL = 3'd2,
		MODE_RISE = 3'd3,
		MODE_BOTH = 3'd4
	} mode_t;

	typedef logic [LINES-1:0][MODE_W-1:0] mode_arr_t;

endpackage

// ===== rtl/eic_in_if.sv =====
interface eic_in_if;
	logic                          valid;
	logic                          ready;
	logic [eic_pkg::CMD_W-1:0]     command;
	logic [eic_pkg::PIN_W-1:0]     pin_levels;
	logic [eic_pkg::KIND_W-1:0]    register_kind;
	logic [eic_pkg::GROUP_W-1:0]   group;
	logic [eic_pkg::WORD_W-1:0]    write_data;

	modport source (output valid, command, pin_levels, register_kind, group, write_data,
		input ready);
	modport sink (input valid, command, pin_levels, register_kind, group, write_data,
		output ready);
endinterface

// ===== rtl/eic_out_if.sv =====
interface eic_out_if;
	logic                        valid;
	logic                        ready;
	logic [eic_pkg::WORD_W-1:0]  read_data;
	logic [eic_pkg::PIN_W-1:0]   active_lines;
	logic                        any_interrupt;

	modport source (output valid, read_data, active_lines, any_interrupt, input ready);
	modport sink (input valid, read_data, active_lines, any_interrupt, output ready);
endinterface

// ===== rtl/external_interrupt_controller.sv =====
// External interrupt controller, 32 lines in four groups of eight.
// req channel: one beat is a command - sample all pin levels, or read or
//   write the trigger control, mask or pending word of one group.
//   Pending bits are write-one-to-clear; edges are seen against the
//   previous sample beat.
// rsp channel: one beat per request beat, in order, giving the word read
//   (zero if not a read), the pending and unmasked lines, and an
//   any-interrupt flag, all as they stand after the request took effect.
// Flow: a request beat is registered in the input register at the edge that
//   takes it, worked on combinationally, and its response registered in the
//   response register once that slot is free or emptying. Throughput is one
//   beat per cycle while rsp is not held off; the input register and the
//   response register let a new beat in while a response waits.
// Reset (arst_n low): all lines masked, low-level trigger, nothing pending,
//   previous pin levels zero; both channels empty.
// Stall: while rsp is held off, the response stays put and the state does
//   not move; one more request beat is taken into the input register, then
//   req.ready drops until the response is taken.
`include "external_interrupt_controller_defines.svh"

module external_interrupt_controller (
	input  logic      clk,
	input  logic      arst_n,
	eic_in_if.sink    req,
	eic_out_if.source rsp
);

	// input register
	logic                          valid_s1;
	logic [eic_pkg::CMD_W-1:0]     cmd_s1;
	logic [eic_pkg::PIN_W-1:0]     pins_s1;
	logic [eic_pkg::KIND_W-1:0]    kind_s1;
	logic [eic_pkg::GROUP_W-1:0]   group_s1;
	logic [eic_pkg::WORD_W-1:0]    wdata_s1;

	// controller state
	eic_pkg::mode_arr_t            mode_q;
	logic [eic_pkg::LINES-1:0]     mask_q;
	logic [eic_pkg::LINES-1:0]     pend_q;
	logic [eic_pkg::LINES-1:0]     prev_q;

	// response register
	logic                          rsp_valid_q;
	logic [eic_pkg::WORD_W-1:0]    rdata_q;
	logic [eic_pkg::PIN_W-1:0]     active_q;
	logic                          any_q;

	// next values
	eic_pkg::mode_arr_t            mode_d;
	logic [eic_pkg::LINES-1:0]     mask_d;
	logic [eic_pkg::LINES-1:0]     pend_d;
	logic [eic_pkg::LINES-1:0]     prev_d;
	logic [eic_pkg::WORD_W-1:0]    rdata_d;
	logic [eic_pkg::LINES-1:0]     live_d;
	logic [eic_pkg::PIN_W-1:0]     active_d;

	logic adv;

	// the staged beat moves on when the response slot is free or emptying
	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1   <= req.command;
			pins_s1  <= req.pin_levels;
			kind_s1  <= req.register_kind;
			group_s1 <= req.group;
			wdata_s1 <= req.write_data;
		end
	end

	always_comb begin
		logic now_lvl;
		logic was_lvl;
		logic hit;
		int   n;

		now_lvl = 1'b0;
		was_lvl = 1'b0;
		hit     = 1'b0;
		n       = 0;
		mode_d  = mode_q;
		mask_d  = mask_q;
		pend_d  = pend_q;
		prev_d  = prev_q;
		rdata_d = '0;

		case (eic_pkg::cmd_t'(cmd_s1))
			eic_pkg::CMD_SAMPLE: begin
				for (int ln = 0; ln < eic_pkg::LINES; ln++) begin
					now_lvl = 1'b0;
					if (ln < eic_pkg::PIN_W) begin
						now_lvl = pins_s1[ln];
					end
					was_lvl = prev_q[ln];
					case (eic_pkg::mode_t'(mode_q[ln]))
						eic_pkg::MODE_LOW:  hit = !now_lvl;
						eic_pkg::MODE_HIGH: hit = now_lvl;
						eic_pkg::MODE_FALL: hit = was_lvl && !now_lvl;
						eic_pkg::MODE_RISE: hit = !was_lvl && now_lvl;
						eic_pkg::MODE_BOTH: hit = was_lvl != now_lvl;
						default:            hit = 1'b0;
					endcase
					if (hit) begin
						pend_d[ln] = 1'b1;
					end
					prev_d[ln] = now_lvl;
				end
			end
			eic_pkg::CMD_READ: begin
				for (int g = 0; g < eic_pkg::GROUPS; g++) begin
					for (int i = 0; i < eic_pkg::LINES_PER_GROUP; i++) begin
						n = g * eic_pkg::LINES_PER_GROUP + i;
						if (int'(group_s1) == g) begin
							case (eic_pkg::kind_t'(kind_s1))
								eic_pkg::KIND_CTRL:
									rdata_d[i*eic_pkg::NIBBLE_W +: eic_pkg::MODE_W] =
										mode_q[n];
								eic_pkg::KIND_MASK: rdata_d[i] = mask_q[n];
								eic_pkg::KIND_PEND: rdata_d[i] = pend_q[n];
								default: ;
							endcase
						end
					end
				end
			end
			eic_pkg::CMD_WRITE: begin
				for (int g = 0; g < eic_pkg::GROUPS; g++) begin
					for (int i = 0; i < eic_pkg::LINES_PER_GROUP; i++) begin
						n = g * eic_pkg::LINES_PER_GROUP + i;
						if (int'(group_s1) == g) begin
							case (eic_pkg::kind_t'(kind_s1))
								eic_pkg::KIND_CTRL:
									mode_d[n] =
										wdata_s1[i*eic_pkg::NIBBLE_W +: eic_pkg::MODE_W];
								eic_pkg::KIND_MASK: mask_d[n] = wdata_s1[i];
								eic_pkg::KIND_PEND: begin
									if (wdata_s1[i]) begin
										pend_d[n] = 1'b0;
									end
								end
								default: ;
							endcase
						end
					end
				end
			end
			default: ;
		endcase

		live_d   = pend_d & ~mask_d;
		active_d = '0;
		for (int b = 0; b < eic_pkg::PIN_W; b++) begin
			if (b < eic_pkg::LINES) begin
				active_d[b] = live_d[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			mode_q      <= '0;
			mask_q      <= '1;
			pend_q      <= '0;
			prev_q      <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
			if (adv && valid_s1) begin
				mode_q <= mode_d;
				mask_q <= mask_d;
				pend_q <= pend_d;
				prev_q <= prev_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rdata_q  <= rdata_d;
			active_q <= active_d;
			any_q    <= |live_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_data     = rdata_q;
	assign rsp.active_lines  = active_q;
	assign rsp.any_interrupt = any_q;

	// reset state: everything masked, nothing pending, from the edge after reset is seen
	`EIC_ASSERT_ALWAYS(a_reset_state, (!arst_n) |=> (mask_q == '1 && pend_q == '0), "reset state wrong")
	// a pending bit only rises on a sample beat
	`EIC_ASSERT(a_pend_rise_on_sample, (!(adv && valid_s1 && cmd_s1 == eic_pkg::CMD_SAMPLE)) |=> ((pend_q & ~$past(pend_q)) == '0), "pending rose without sample")
	// while the response is held off, the state does not move
	`EIC_ASSERT(a_state_frozen_on_stall, (valid_s1 && !adv) |=> ($stable(pend_q) && $stable(mask_q) && $stable(mode_q)), "state moved during stall")
	// either every shown active line is still active for the staged beat, or none is masked in the current state
	`EIC_ASSERT(a_active_unmasked, rsp_valid_q |-> ((rsp.active_lines & ~active_d) == '0 || (rsp.active_lines & mask_q[eic_pkg::PIN_W-1:0]) == '0), "masked line reported active")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import eic_pkg::*;

	// Codes that the package has no member for: the spare command and the
	// spare register kind. Both must leave the state alone.
	localparam logic [CMD_W-1:0]  CMD_NONE  = 2'd3;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	localparam int RANDOM_BEATS = 850;
	localparam int CALM_FROM    = 730;	// no idling from here to the end
	localparam int DRAIN_AT     = 400;	// sender waits for an empty pipe here

	typedef struct {
		logic [WORD_W-1:0] read_data;
		logic [PIN_W-1:0]  active_lines;
		logic              any_interrupt;
	} response_t;

	// Shadow of the controller: trigger modes, masks, pending bits and the
	// pin levels of the last sample beat, plus the responses still owed.
	class irq_scoreboard;
		logic [MODE_W-1:0] trig [LINES];
		logic [LINES-1:0]  masked;
		logic [LINES-1:0]  pending;
		logic [LINES-1:0]  prev_pins;
		response_t         due_responses [$];
		int                failures;
		int                checked;

		function new();
			foreach (trig[l])
				trig[l] = MODE_LOW;
			masked    = '1;
			pending   = '0;
			prev_pins = '0;
			failures  = 0;
			checked   = 0;
		endfunction

		// Applies one accepted request beat and queues the response it owes.
		function void predict_response(logic [CMD_W-1:0] cmd, logic [PIN_W-1:0] pins,
				logic [KIND_W-1:0] kind, logic [GROUP_W-1:0] grp,
				logic [WORD_W-1:0] data);
			response_t        r;
			logic             hit;
			int               n;
			logic [LINES-1:0] live;
			r.read_data = '0;
			case (cmd)
				CMD_SAMPLE: begin
					for (int l = 0; l < LINES; l++) begin
						case (trig[l])
							MODE_LOW:  hit = !pins[l];
							MODE_HIGH: hit = pins[l];
							MODE_FALL: hit = prev_pins[l] && !pins[l];
							MODE_RISE: hit = !prev_pins[l] && pins[l];
							MODE_BOTH: hit = prev_pins[l] != pins[l];
							default:   hit = 1'b0;
						endcase
						if (hit)
							pending[l] = 1'b1;
					end
					prev_pins = pins[LINES-1:0];
				end
				CMD_READ: begin
					if (int'(grp) < GROUPS && kind <= KIND_PEND) begin
						for (int i = 0; i < LINES_PER_GROUP; i++) begin
							n = int'(grp) * LINES_PER_GROUP + i;
							case (kind)
								KIND_CTRL: r.read_data[NIBBLE_W*i +: MODE_W] = trig[n];
								KIND_MASK: r.read_data[i] = masked[n];
								default:   r.read_data[i] = pending[n];
							endcase
						end
					end
				end
				CMD_WRITE: begin
					if (int'(grp) < GROUPS && kind <= KIND_PEND) begin
						for (int i = 0; i < LINES_PER_GROUP; i++) begin
							n = int'(grp) * LINES_PER_GROUP + i;
							case (kind)
								KIND_CTRL: trig[n] = data[NIBBLE_W*i +: MODE_W];
								KIND_MASK: masked[n] = data[i];
								default: begin
									if (data[i])
										pending[n] = 1'b0;
								end
							endcase
						end
					end
				end
				default: ;
			endcase
			live            = pending & ~masked;
			r.active_lines  = live;
			r.any_interrupt = |live;
			due_responses.push_back(r);
		endfunction

		function void check_response(logic [WORD_W-1:0] rd, logic [PIN_W-1:0] act,
				logic any);
			response_t e;
			if (due_responses.size() == 0) begin
				$error("response beat with nothing outstanding");
				failures++;
				return;
			end
			e = due_responses.pop_front();
			checked++;
			if (rd !== e.read_data) begin
				$error("read_data: expected %h, got %h", e.read_data, rd);
				failures++;
			end
			if (act !== e.active_lines) begin
				$error("active_lines: expected %h, got %h", e.active_lines, act);
				failures++;
			end
			if (any !== e.any_interrupt) begin
				$error("any_interrupt: expected %b, got %b", e.any_interrupt, any);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_idling;	// shared by both sides: suppresses gaps and stalls

	int n_sample, n_read, n_write, n_none;
	logic [PIN_W-1:0] last_pins;

	irq_scoreboard sb;

	eic_in_if  req();
	eic_out_if rsp();

	external_interrupt_controller uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog. A correct run needs well under a millisecond even with
	// every gap and stall at its longest.
	initial begin
		#3_000_000;
		$display("external_interrupt_controller regression: fail");
		$finish;
	end

	// Offers one request beat from a falling edge, holds it until taken,
	// and returns at the next falling edge with valid still high.
	task automatic send_beat(logic [CMD_W-1:0] cmd, logic [PIN_W-1:0] pins,
			logic [KIND_W-1:0] kind, logic [GROUP_W-1:0] grp, logic [WORD_W-1:0] data);
		req.valid         <= 1'b1;
		req.command       <= cmd;
		req.pin_levels    <= pins;
		req.register_kind <= kind;
		req.group         <= grp;
		req.write_data    <= data;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		sb.predict_response(cmd, pins, kind, grp, data);
		case (cmd)
			CMD_SAMPLE: n_sample++;
			CMD_READ:   n_read++;
			CMD_WRITE:  n_write++;
			default:    n_none++;
		endcase
		@(negedge clk);
	endtask

	// The unused fields carry noise so that the block is seen to ignore them.
	task automatic do_sample(logic [PIN_W-1:0] pins);
		send_beat(CMD_SAMPLE, pins, KIND_W'($urandom), GROUP_W'($urandom), $urandom);
		last_pins = pins;
	endtask

	task automatic do_read(logic [KIND_W-1:0] kind, logic [GROUP_W-1:0] grp);
		send_beat(CMD_READ, $urandom, kind, grp, $urandom);
	endtask

	task automatic do_write(logic [KIND_W-1:0] kind, logic [GROUP_W-1:0] grp,
			logic [WORD_W-1:0] data);
		send_beat(CMD_WRITE, $urandom, kind, grp, data);
	endtask

	task automatic pause(int cycles);
		req.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Hold off until every owed response has been taken. Always waits for a
	// falling edge first so valid is never lowered and raised in one step.
	task automatic drain();
		req.valid <= 1'b0;
		@(negedge clk);
		while (sb.due_responses.size() != 0)
			@(negedge clk);
	endtask

	// Response side: ready low in bursts whose length is drawn at random, else high.
	initial begin
		int hold;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!no_idling && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 6);
				rsp.ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Response checker: outputs sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_response(rsp.read_data, rsp.active_lines, rsp.any_interrupt);
	end

	initial begin
		logic [PIN_W-1:0]  pins;
		logic [WORD_W-1:0] data;
		int                pick;
		sb        = new();
		no_idling = 1'b0;
		last_pins = '0;
		n_sample  = 0;
		n_read    = 0;
		n_write   = 0;
		n_none    = 0;
		req.valid         <= 1'b0;
		req.command       <= CMD_SAMPLE;
		req.pin_levels    <= '0;
		req.register_kind <= KIND_CTRL;
		req.group         <= '0;
		req.write_data    <= '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed beats ---
		do_read(KIND_MASK, 2'd3);			// reset value: all masked
		do_sample('1);					// low level mode, all pins high: nothing
		// group 0: high, fall, rise, both, three never-trigger codes, and a
		// nibble with bit 3 set that must read back as low level
		do_write(KIND_CTRL, 2'd0, 32'h8765_4321);
		do_write(KIND_CTRL, 2'd1, 32'hFFFF_FFFF);	// never trigger
		do_write(KIND_CTRL, 2'd2, 32'h4444_4444);	// both edges
		do_write(KIND_CTRL, 2'd3, 32'h8888_8888);	// low level, bit 3 ignored
		do_read(KIND_CTRL, 2'd0);
		do_write(KIND_MASK, 2'd0, 32'hFFFF_FF00);	// bits above the group ignored
		do_write(KIND_MASK, 2'd1, 32'h0000_0000);
		do_write(KIND_MASK, 2'd2, 32'h0000_0000);
		do_write(KIND_MASK, 2'd3, 32'h0000_00AA);
		do_sample('0);					// falls everywhere
		do_sample('1);					// rises everywhere
		do_sample(32'h5555_AAAA);
		do_read(KIND_PEND, 2'd0);
		do_read(KIND_PEND, 2'd1);
		do_read(KIND_PEND, 2'd2);
		do_read(KIND_PEND, 2'd3);
		do_write(KIND_PEND, 2'd0, 32'h0000_00FF);	// write one to clear
		do_write(KIND_PEND, 2'd2, 32'hFFFF_FF0F);
		do_write(KIND_NONE, 2'd0, 32'hFFFF_FFFF);	// spare kind: ignored
		do_read(KIND_NONE, 2'd1);			// spare kind reads zero
		send_beat(CMD_NONE, '1, KIND_PEND, 2'd3, '1);	// spare command: no action
		do_read(KIND_MASK, 2'd3);
		do_read(KIND_PEND, 2'd3);
		drain();

		// --- random beats ---
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			// stretches of back-to-back traffic, then a calm tail
			if (i % 64 == 0)
				no_idling = ($urandom_range(0, 3) == 0);
			if (i >= CALM_FROM)
				no_idling = 1'b1;
			if (i == DRAIN_AT)
				drain();
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				case ($urandom_range(0, 3))
					0, 1: pins = last_pins ^ (PIN_W'(1) << $urandom_range(0, PIN_W - 1))
						^ ($urandom & $urandom & $urandom);
					2:    pins = $urandom;
					default: pins = $urandom_range(0, 1) ? '1 : '0;
				endcase
				do_sample(pins);
			end else if (pick < 70) begin
				do_read(KIND_W'($urandom), GROUP_W'($urandom));
			end else if (pick < 95) begin
				// masks lean towards unmasked so that pending lines show
				data = $urandom_range(0, 1) ? ($urandom & $urandom) : $urandom;
				do_write(KIND_W'($urandom), GROUP_W'($urandom), data);
			end else begin
				send_beat(CMD_NONE, $urandom, KIND_W'($urandom), GROUP_W'($urandom),
					$urandom);
			end
			if (!no_idling && $urandom_range(0, 7) == 0)
				pause($urandom_range(1, 6));
		end
		req.valid <= 1'b0;

		while (sb.due_responses.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("beats sent: %0d samples, %0d reads, %0d writes, %0d spare commands",
			n_sample, n_read, n_write, n_none);
		$display("responses checked: %0d, mismatches: %0d", sb.checked, sb.failures);
		if (sb.failures == 0) begin
			$display("external_interrupt_controller regression: pass");
		end else begin
			$display("external_interrupt_controller regression: fail");
		end
		$finish;
	end

endmodule
